FILE: src/ssms_pkg.sv
package ssms_pkg;

  // Fixed field widths of the input and result words
  localparam int unsigned SampleW = 32;
  localparam int unsigned SpanW   = 32;
  localparam int unsigned TotalW  = 63;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PUSH
  } state_e;

endpackage

FILE: src/ssms_if.sv
// Input channel: one sample word per handshake
interface ssms_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ssms_pkg::SampleW-1:0] sample_value;
  logic                               restart;

  modport source (output valid, output sample_value, output restart, input ready);
  modport sink   (input valid, input sample_value, input restart, output ready);
endinterface

// Result channel: one span word per handshake
interface ssms_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssms_pkg::SpanW-1:0]   span_count;
  logic [ssms_pkg::TotalW-1:0]  span_total;
  logic                         overflow_seen;

  modport source (output valid, output span_count, output span_total, output overflow_seen,
                  input ready);
  modport sink   (input valid, input span_count, input span_total, input overflow_seen,
                  output ready);
endinterface

FILE: src/ssms_mem.sv
// Stack store: one write port, one read port, registered read data
module ssms_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/stock_span_monotonic_stack_top.sv
// Stock span engine over a monotonic (value, span) stack held in a ring memory.
// A word that pops nothing passes from IDLE through CMP or PUSH to the result register;
// each popped entry adds a CMP step; a stalled result port holds the push back until it frees.
// A new word is taken only in IDLE, once the last one is pushed; the stack read loop sets the pace.
// Reset: asynchronous, stack empty, total and overflow flag cleared; no clearing pass.
module stock_span_monotonic_stack_top #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssms_in_if.sink     in_i,
  ssms_out_if.source  out_o
);

  localparam int unsigned AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SW   = AW + 1;
  localparam int unsigned FW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned KW   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned SpW  = ssms_pkg::SpanW;
  localparam int unsigned ToW  = ssms_pkg::TotalW;
  localparam int unsigned MemW = KW + SpW;

  // ring position of an offset above the bottom entry
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [SW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + off;
    if (s >= SW'(STACK_DEPTH)) begin
      s = s - SW'(STACK_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  ssms_pkg::state_e state_q, state_d;

  logic [KW-1:0]  key_q, key_d;
  logic [SpW-1:0] span_q, span_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [AW-1:0]  bottom_q, bottom_d;
  logic [ToW-1:0] total_q, total_d;
  logic           ovf_q, ovf_d;

  logic           out_valid_q, out_valid_d;
  logic [SpW-1:0] out_span_q, out_span_d;
  logic [ToW-1:0] out_total_q, out_total_d;
  logic           out_ovf_q, out_ovf_d;

  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [MemW-1:0] wr_data, rd_data;

  logic [KW-1:0]   rd_value;
  logic [SpW-1:0]  rd_span;
  logic [SpW:0]    span_sum;
  logic [SpW-1:0]  span_sat;
  logic [ToW:0]    total_sum;
  logic [ToW-1:0]  total_sat;
  logic            out_free;
  logic            pop;
  logic [FW-1:0]   acc_fill;
  logic [AW-1:0]   acc_bottom;
  logic [FW-1:0]   psh_fill;
  logic [AW-1:0]   psh_bottom;
  logic            psh_full;

  ssms_mem #(
    .Depth (STACK_DEPTH),
    .Width (MemW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_value = rd_data[MemW-1:SpW];
  assign rd_span  = rd_data[SpW-1:0];

  // saturating span and total adders
  assign span_sum  = {1'b0, span_q} + {1'b0, rd_span};
  assign span_sat  = span_sum[SpW] ? '1 : span_sum[SpW-1:0];
  assign total_sum = {1'b0, total_q} + (ToW + 1)'(span_q);
  assign total_sat = total_sum[ToW] ? '1 : total_sum[ToW-1:0];

  assign out_free = !out_valid_q || out_o.ready;
  assign pop      = $signed(rd_value) <= $signed(key_q);

  // push geometry: drop the bottom entry when still full
  assign psh_full   = (fill_q == FW'(STACK_DEPTH));
  assign psh_bottom = psh_full ? slot_of(bottom_q, SW'(1)) : bottom_q;
  assign psh_fill   = psh_full ? FW'(STACK_DEPTH - 1) : fill_q;

  // restart applies before the word is processed
  assign acc_fill   = in_i.restart ? '0 : fill_q;
  assign acc_bottom = in_i.restart ? '0 : bottom_q;

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    span_d      = span_q;
    fill_d      = fill_q;
    bottom_d    = bottom_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_span_d  = out_span_q;
    out_total_d = out_total_q;
    out_ovf_d   = out_ovf_q;
    rd_en       = 1'b0;
    rd_addr     = slot_of(bottom_q, SW'(fill_q) - SW'(1));
    wr_en       = 1'b0;
    wr_addr     = slot_of(psh_bottom, SW'(psh_fill));
    wr_data     = {key_q, span_q};
    in_i.ready  = 1'b0;

    unique case (state_q)
      ssms_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          key_d    = in_i.sample_value[KW-1:0];
          span_d   = SpW'(1);
          fill_d   = acc_fill;
          bottom_d = acc_bottom;
          if (in_i.restart) begin
            total_d = '0;
            ovf_d   = 1'b0;
          end
          if (acc_fill != '0) begin
            rd_en   = 1'b1;
            rd_addr = slot_of(acc_bottom, SW'(acc_fill) - SW'(1));
            state_d = ssms_pkg::ST_CMP;
          end else begin
            state_d = ssms_pkg::ST_PUSH;
          end
        end
      end

      ssms_pkg::ST_CMP: begin
        if (pop) begin
          span_d = span_sat;
          fill_d = fill_q - FW'(1);
          if (fill_q != FW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = slot_of(bottom_q, SW'(fill_q) - SW'(2));
          end else begin
            state_d = ssms_pkg::ST_PUSH;
          end
        end else if (out_free) begin
          wr_en       = 1'b1;
          fill_d      = psh_fill + FW'(1);
          bottom_d    = psh_bottom;
          ovf_d       = ovf_q | psh_full;
          total_d     = total_sat;
          out_valid_d = 1'b1;
          out_span_d  = span_q;
          out_total_d = total_sat;
          out_ovf_d   = ovf_q | psh_full;
          state_d     = ssms_pkg::ST_IDLE;
        end else begin
          state_d = ssms_pkg::ST_PUSH;
        end
      end

      ssms_pkg::ST_PUSH: begin
        if (out_free) begin
          wr_en       = 1'b1;
          fill_d      = psh_fill + FW'(1);
          bottom_d    = psh_bottom;
          ovf_d       = ovf_q | psh_full;
          total_d     = total_sat;
          out_valid_d = 1'b1;
          out_span_d  = span_q;
          out_total_d = total_sat;
          out_ovf_d   = ovf_q | psh_full;
          state_d     = ssms_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ssms_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssms_pkg::ST_IDLE;
      fill_q      <= '0;
      bottom_q    <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bottom_q    <= bottom_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    span_q      <= span_d;
    out_span_q  <= out_span_d;
    out_total_q <= out_total_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.span_count    = out_span_q;
  assign out_o.span_total    = out_total_q;
  assign out_o.overflow_seen = out_ovf_q;

endmodule

FILE: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned ResetLen   = 12;
  localparam int unsigned EndHold    = 300;   // longest pop chain plus margin
  localparam int unsigned PhaseLen   = 450;
  localparam longint unsigned SpanCap  = 64'h0000_0000_FFFF_FFFF;
  localparam longint unsigned TotalCap = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ssms_pkg::SampleW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ssms_pkg::SampleW-1:0] ValMin = 32'sh8000_0000;

  typedef struct packed {
    logic [ssms_pkg::SpanW-1:0]  span;
    logic [ssms_pkg::TotalW-1:0] total;
    logic                        ovf;
  } span_word_t;

  // Span predictor with its own copy of the ring stack, plus the queue of
  // span words still to come out of the block
  class span_scoreboard;
    logic signed [ssms_pkg::SampleW-1:0] ring_val [StackDepth];
    logic [ssms_pkg::SpanW-1:0]          ring_span [StackDepth];
    int unsigned                         fill;
    int unsigned                         bottom;
    logic [ssms_pkg::TotalW-1:0]         total;
    logic                                ovf;
    span_word_t                          pending_spans [$];
    int unsigned                         errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      fill   = 0;
      bottom = 0;
      total  = '0;
      ovf    = 1'b0;
    endfunction

    // Work out the span word for one accepted sample
    function void note_sample(logic signed [ssms_pkg::SampleW-1:0] v, logic restart);
      longint unsigned span;
      int unsigned     top;
      int unsigned     slot;
      span_word_t      w;
      span = 1;
      if (restart) clear();
      // pop every entry that is not above the new value
      while (fill > 0) begin
        top = (bottom + fill - 1) % StackDepth;
        if (ring_val[top] > v) break;
        span += ring_span[top];
        if (span > SpanCap) span = SpanCap;
        fill--;
      end
      // still full: drop the bottom entry
      if (fill >= StackDepth) begin
        bottom = (bottom + 1) % StackDepth;
        fill   = StackDepth - 1;
        ovf    = 1'b1;
      end
      slot            = (bottom + fill) % StackDepth;
      ring_val[slot]  = v;
      ring_span[slot] = span[ssms_pkg::SpanW-1:0];
      fill++;
      if (longint'(total) > TotalCap - span) total = TotalCap[ssms_pkg::TotalW-1:0];
      else total = total + span[ssms_pkg::TotalW-1:0];
      w.span  = span[ssms_pkg::SpanW-1:0];
      w.total = total;
      w.ovf   = ovf;
      pending_spans.push_back(w);
    endfunction

    function void check_span(logic [ssms_pkg::SpanW-1:0] span,
                             logic [ssms_pkg::TotalW-1:0] tot, logic ovf_o);
      span_word_t w;
      if (pending_spans.size() == 0) begin
        $error("span word with no sample pending: span_count %0d", span);
        errors++;
        return;
      end
      w = pending_spans.pop_front();
      if (span !== w.span) begin
        $error("span_count: expected %0d, got %0d", w.span, span);
        errors++;
      end
      if (tot !== w.total) begin
        $error("span_total: expected %0d, got %0d", w.total, tot);
        errors++;
      end
      if (ovf_o !== w.ovf) begin
        $error("overflow_seen: expected %0b, got %0b", w.ovf, ovf_o);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ssms_in_if  in_if ();
  ssms_out_if out_if ();

  span_scoreboard sb;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    sent_count     = 0;

  stock_span_monotonic_stack_top #(
    .STACK_DEPTH (StackDepth),
    .VALUE_WIDTH (ValueW)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watch both channels: check the older span word first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_span(out_if.span_count, out_if.span_total, out_if.overflow_seen);
      if (in_if.valid && in_if.ready)
        sb.note_sample(in_if.sample_value, in_if.restart);
    end
  end

  // Offer one sample word and hold it until taken
  task automatic send_sample(logic signed [ssms_pkg::SampleW-1:0] v, logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_value <= v;
    in_if.restart      <= restart;
    do @(posedge clk_i); while (!in_if.ready);
    sent_count++;
  endtask

  // Sender pauses until every span word has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_spans.size() != 0);
  endtask

  // Strictly falling run: no sample pops an earlier sample of the run
  task automatic run_falling(int unsigned len, int unsigned max_shift, logic restart_first);
    logic signed [ssms_pkg::SampleW-1:0] v;
    v = (len > StackDepth) ? ValMax - $urandom_range(0, 1000) : $urandom;
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(v, restart_first && (i == 0));
      v = v - $urandom_range(1, 1 << $urandom_range(0, max_shift));
    end
  endtask

  // Rising run: each sample pops what came before
  task automatic run_rising(int unsigned len);
    logic signed [ssms_pkg::SampleW-1:0] v;
    v = $urandom;
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(v, 1'b0);
      v = v + $urandom_range(0, 1 << $urandom_range(0, 20));
    end
  endtask

  // Narrow value range, so ties are common
  task automatic run_ties(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_sample($signed($urandom_range(0, 7)) - 4, ($urandom_range(99) < 2));
  endtask

  task automatic run_noise(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_sample($urandom, ($urandom_range(99) < 3));
  endtask

  initial begin
    int unsigned pick;
    sb                  = new();
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.sample_value  = '0;
    in_if.restart       = 1'b0;
    out_if.ready        = 1'b0;
    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, ties, full pops and restarts
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd5, 1'b1);
    send_sample(32'sd3, 1'b0);
    send_sample(32'sd3, 1'b0);
    send_sample(32'sd4, 1'b0);
    send_sample(ValMin, 1'b0);
    send_sample(ValMax, 1'b0);
    send_sample(ValMax, 1'b0);
    send_sample(ValMin, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(ValMin, 1'b1);
    send_sample(ValMin, 1'b0);
    send_sample(ValMin + 1, 1'b0);
    send_sample(32'sh5555_5555, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b0);
    send_sample(32'sd100, 1'b1);
    send_sample(32'sd99, 1'b0);
    send_sample(32'sd98, 1'b0);
    send_sample(ValMax, 1'b0);
    drain();

    // Random: four phases of sender idling and receiver stall, with a forced stack overflow at the start of two of them
    for (int unsigned ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (ph == 0 || ph == 3) begin
        run_falling(StackDepth + $urandom_range(4, 40), 16, 1'b1);
        send_sample(ValMax, 1'b0);
      end
      while (sent_count < 21 + PhaseLen * (ph + 1)) begin
        pick = $urandom_range(99);
        if (pick < 35)      run_falling($urandom_range(1, 40), 20, ($urandom_range(99) < 15));
        else if (pick < 55) run_rising($urandom_range(1, 12));
        else if (pick < 70) run_ties($urandom_range(1, 16));
        else if (pick < 72) run_falling(StackDepth + $urandom_range(1, 20), 16, 1'b0);
        else                run_noise($urandom_range(1, 10));
      end
      drain();
    end

    repeat (EndHold) @(posedge clk_i);
    if (sb.pending_spans.size() != 0) begin
      $error("%0d span words never arrived", sb.pending_spans.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
